### hw/rtl/cnd_pkg.sv
// Package for the cash note dispenser: types, constants and the control-store program.
`default_nettype none
package cnd_pkg;

	localparam int MODE_W     = 2;
	localparam int BAL_W      = 31;
	localparam int STK_W      = 16;
	localparam int SLOT_W     = 4;
	localparam int NDEN       = 5;
	localparam int DEN_W      = 3;
	localparam int HIST_DEPTH = 10;
	localparam int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int HCNT_W     = $clog2(HIST_DEPTH + 1);
	localparam int HOUT_W     = 4;
	localparam int HMAX_W     = (HIDX_W > SLOT_W) ? ((HIDX_W > HCNT_W) ? HIDX_W : HCNT_W)
	                          : ((SLOT_W > HCNT_W) ? SLOT_W : HCNT_W);
	localparam int HSUM_W     = HMAX_W + 1;

	// amount in units of 5000
	localparam int UNIT_W  = 19;
	localparam int SUM_W   = 22;
	localparam int BPROD_W = 35;
	localparam int BSUM_W  = 36;
	localparam int KPROD_W = 57;
	localparam int K_SH    = 38;
	localparam int DPROD_W = 40;
	localparam int D_SH    = 21;
	localparam int CHK_W   = 32;
	localparam int TAKE_W  = 24;

	localparam logic [BAL_W-1:0]  BAL_MAX   = {BAL_W{1'b1}};
	localparam logic [STK_W-1:0]  STK_MAX   = {STK_W{1'b1}};
	localparam logic [BAL_W-1:0]  BAL_RST   = 31'd5000000;
	localparam logic [12:0]       NOTE_VAL  = 13'd5000;
	localparam logic [28:0]       RECIP_625 = 29'd439804652;
	localparam logic [18:0]       RECIP_5   = 19'd419431;

	localparam logic [STK_W-1:0] STOCK_RST [NDEN] = '{16'd10, 16'd20, 16'd50, 16'd100, 16'd200};
	localparam logic [4:0]       DENOM_UNIT [NDEN] = '{5'd20, 5'd10, 5'd4, 5'd2, 5'd1};
	localparam logic [1:0]       DENOM_SHIFT [NDEN] = '{2'd2, 2'd1, 2'd2, 2'd1, 2'd0};
	localparam logic             DENOM_DIV5 [NDEN] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

	localparam logic [MODE_W-1:0] MODE_WDR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RFL = 2'd1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVER     = 2'd1,
		ST_NOT_MULT = 2'd2,
		ST_SHORT    = 2'd3
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BAL_W-1:0]  amount;
		logic [STK_W-1:0]  add_hundred_k;
		logic [STK_W-1:0]  add_fifty_k;
		logic [STK_W-1:0]  add_twenty_k;
		logic [STK_W-1:0]  add_ten_k;
		logic [STK_W-1:0]  add_five_k;
		logic [SLOT_W-1:0] history_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [STK_W-1:0]  notes_hundred_k;
		logic [STK_W-1:0]  notes_fifty_k;
		logic [STK_W-1:0]  notes_twenty_k;
		logic [STK_W-1:0]  notes_ten_k;
		logic [STK_W-1:0]  notes_five_k;
		logic [BAL_W-1:0]  balance_now;
		logic [BAL_W-1:0]  history_amount;
		logic [HOUT_W-1:0] history_used;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CHK,
		OP_MOD,
		OP_DIV,
		OP_TAKE,
		OP_COMMIT,
		OP_RSUM,
		OP_RBAL,
		OP_OUT
	} op_t;

	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
	localparam logic [PC_W-1:0] PC_WDR  = 5'd1;
	localparam logic [PC_W-1:0] PC_RFL  = 5'd14;
	localparam logic [PC_W-1:0] PC_OUT  = 5'd16;

	typedef struct packed {
		op_t              op;
		logic [DEN_W-1:0] den;
		logic [PC_W-1:0]  nxt;
		logic [PC_W-1:0]  jmp;
	} ctl_t;

	function automatic ctl_t cw(op_t op, int den, int nxt, logic [PC_W-1:0] jmp);
		ctl_t c;
		c.op  = op;
		c.den = DEN_W'(den);
		c.nxt = PC_W'(nxt);
		c.jmp = jmp;
		return c;
	endfunction

	function automatic ctl_t ucode(logic [PC_W-1:0] pc);
		ctl_t c;
		case (pc)
			5'd0:    c = cw(OP_IDLE,   0, 0,  PC_IDLE);
			5'd1:    c = cw(OP_CHK,    0, 2,  PC_IDLE);
			5'd2:    c = cw(OP_MOD,    0, 3,  PC_OUT);
			5'd3:    c = cw(OP_DIV,    0, 4,  PC_IDLE);
			5'd4:    c = cw(OP_TAKE,   0, 5,  PC_IDLE);
			5'd5:    c = cw(OP_DIV,    1, 6,  PC_IDLE);
			5'd6:    c = cw(OP_TAKE,   1, 7,  PC_IDLE);
			5'd7:    c = cw(OP_DIV,    2, 8,  PC_IDLE);
			5'd8:    c = cw(OP_TAKE,   2, 9,  PC_IDLE);
			5'd9:    c = cw(OP_DIV,    3, 10, PC_IDLE);
			5'd10:   c = cw(OP_TAKE,   3, 11, PC_IDLE);
			5'd11:   c = cw(OP_DIV,    4, 12, PC_IDLE);
			5'd12:   c = cw(OP_TAKE,   4, 13, PC_IDLE);
			5'd13:   c = cw(OP_COMMIT, 0, 16, PC_IDLE);
			5'd14:   c = cw(OP_RSUM,   0, 15, PC_IDLE);
			5'd15:   c = cw(OP_RBAL,   0, 16, PC_IDLE);
			5'd16:   c = cw(OP_OUT,    0, 0,  PC_IDLE);
			default: c = cw(OP_IDLE,   0, 0,  PC_IDLE);
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/cash_note_dispenser.sv
// Cash note dispenser: balance, note stocks and withdrawal history behind a microcoded datapath.
//
// Requests enter on req/req_valid/req_stall and are taken when req_valid is high and
// req_stall low; one response per request leaves on rsp/rsp_valid/rsp_stall.
// req_stall is high while the sequencer works on a request, one request at a time.
// A withdraw runs check, modulo, the divide/take pairs and commit, then the output
// step; refused for balance or multiple, it jumps from modulo to output. Refill runs
// sum and balance steps, a query goes to output; idle resumes when the response is registered.
// Withdraw runs five divide/take step pairs of the control store, one per note
// denomination, through one shared divide-by-constant multiplier.
// The response sits in an output register; while rsp_stall holds it, a new request
// can still be accepted and worked up to its output step, where it waits.
// Reset (arst_n low) sets balance 5000000 and stocks 10/20/50/100/200 notes, empties
// the history and drops any pending response.
`default_nettype none
module cash_note_dispenser (
	input  wire  logic          clk,
	input  wire  logic          arst_n,
	input  wire  logic          req_valid,
	output       logic          req_stall,
	input  wire  cnd_pkg::req_t req,
	output       logic          rsp_valid,
	input  wire  logic          rsp_stall,
	output       cnd_pkg::rsp_t rsp
);
	import cnd_pkg::*;

	logic [PC_W-1:0]   pc_q, pc_d;
	ctl_t              ctl;
	logic              accept, rsp_go;

	req_t              req_q;
	logic [BAL_W-1:0]  balance_q;
	logic [STK_W-1:0]  stock_q [NDEN];
	logic [STK_W-1:0]  pick_q [NDEN];
	logic [BAL_W-1:0]  hist_q [HIST_DEPTH];
	logic [HCNT_W-1:0] hcount_q;
	logic [HIDX_W-1:0] hhead_q;
	logic [UNIT_W-1:0] k_q, rest_q, quo_q;
	logic              over_q;
	status_t           status_q;
	logic [SUM_W-1:0]  sum_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [STK_W-1:0]   add_v [NDEN];
	logic [KPROD_W-1:0] k_prod;
	logic               mult_ok;
	logic [UNIT_W-1:0]  div_x;
	logic [DPROD_W-1:0] div_prod;
	logic [UNIT_W-1:0]  quo_d;
	logic [STK_W-1:0]   take_stk, take_n;
	logic [UNIT_W-1:0]  rest_d;
	logic               full;
	logic [HSUM_W-1:0]  wr_sum, rd_sum;
	logic [HIDX_W-1:0]  wr_idx, rd_idx, head_inc;
	logic               rd_hit;
	logic [SUM_W-1:0]   sum_d;
	logic [BPROD_W-1:0] bal_prod;
	logic [BSUM_W-1:0]  bal_sum;
	logic [BAL_W-1:0]   bal_rfl;
	logic [STK_W:0]     stk_sum [NDEN];
	logic [STK_W-1:0]   stk_rfl [NDEN];
	logic [STK_W-1:0]   notes_o [NDEN];
	rsp_t               rsp_d;

	assign ctl       = ucode(pc_q);
	assign req_stall = (ctl.op != OP_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_go    = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign add_v[0] = req_q.add_hundred_k;
	assign add_v[1] = req_q.add_fifty_k;
	assign add_v[2] = req_q.add_twenty_k;
	assign add_v[3] = req_q.add_ten_k;
	assign add_v[4] = req_q.add_five_k;

	// amount / 5000 = (amount >> 3) / 625 by reciprocal
	assign k_prod  = KPROD_W'(req_q.amount >> 3) * KPROD_W'(RECIP_625);
	assign mult_ok = (CHK_W'(k_q) * CHK_W'(NOTE_VAL)) == CHK_W'(req_q.amount);

	// rest / unit: shift, then divide by 5 for the two largest notes
	assign div_x    = rest_q >> DENOM_SHIFT[ctl.den];
	assign div_prod = DPROD_W'(div_x) * DPROD_W'(RECIP_5);
	assign quo_d    = DENOM_DIV5[ctl.den] ? div_prod[D_SH +: UNIT_W] : div_x;

	assign take_stk = stock_q[ctl.den];
	assign take_n   = (quo_q > UNIT_W'(take_stk)) ? take_stk : quo_q[STK_W-1:0];
	assign rest_d   = rest_q - UNIT_W'(TAKE_W'(take_n) * TAKE_W'(DENOM_UNIT[ctl.den]));

	assign full     = (hcount_q == HCNT_W'(HIST_DEPTH));
	assign wr_sum   = HSUM_W'(hhead_q) + HSUM_W'(hcount_q);
	assign wr_idx   = (wr_sum >= HSUM_W'(HIST_DEPTH)) ? HIDX_W'(wr_sum - HSUM_W'(HIST_DEPTH))
	                                                  : HIDX_W'(wr_sum);
	assign head_inc = (hhead_q == HIDX_W'(HIST_DEPTH - 1)) ? '0 : hhead_q + 1'b1;
	assign rd_sum   = HSUM_W'(hhead_q) + HSUM_W'(req_q.history_slot);
	assign rd_idx   = (rd_sum >= HSUM_W'(HIST_DEPTH)) ? HIDX_W'(rd_sum - HSUM_W'(HIST_DEPTH))
	                                                  : HIDX_W'(rd_sum);
	assign rd_hit   = HSUM_W'(req_q.history_slot) < HSUM_W'(hcount_q);

	assign bal_prod = BPROD_W'(sum_q) * BPROD_W'(NOTE_VAL);
	assign bal_sum  = BSUM_W'(balance_q) + BSUM_W'(bal_prod);
	assign bal_rfl  = (bal_sum > BSUM_W'(BAL_MAX)) ? BAL_MAX : bal_sum[BAL_W-1:0];

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NDEN; i++) begin
			stk_sum[i] = (STK_W+1)'(stock_q[i]) + (STK_W+1)'(add_v[i]);
			stk_rfl[i] = stk_sum[i][STK_W] ? STK_MAX : stk_sum[i][STK_W-1:0];
			sum_d      = sum_d + SUM_W'(add_v[i]) * SUM_W'(DENOM_UNIT[i]);
			notes_o[i] = (req_q.mode == MODE_WDR) ? pick_q[i] : stock_q[i];
		end
	end

	always_comb begin
		rsp_d.status          = status_q;
		rsp_d.notes_hundred_k = notes_o[0];
		rsp_d.notes_fifty_k   = notes_o[1];
		rsp_d.notes_twenty_k  = notes_o[2];
		rsp_d.notes_ten_k     = notes_o[3];
		rsp_d.notes_five_k    = notes_o[4];
		rsp_d.balance_now     = balance_q;
		rsp_d.history_amount  = rd_hit ? hist_q[rd_idx] : '0;
		rsp_d.history_used    = HOUT_W'(hcount_q);
	end

	always_comb begin
		case (ctl.op)
			OP_IDLE: begin
				if (!accept)
					pc_d = pc_q;
				else if (req.mode == MODE_WDR)
					pc_d = PC_WDR;
				else if (req.mode == MODE_RFL)
					pc_d = PC_RFL;
				else
					pc_d = PC_OUT;
			end
			OP_MOD:  pc_d = (over_q || !mult_ok) ? ctl.jmp : ctl.nxt;
			OP_OUT:  pc_d = rsp_go ? ctl.nxt : pc_q;
			default: pc_d = ctl.nxt;
		endcase
	end

	// sequencer, architectural state, response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			rsp_valid_q <= 1'b0;
			balance_q   <= BAL_RST;
			hcount_q    <= '0;
			hhead_q     <= '0;
			for (int i = 0; i < NDEN; i++)
				stock_q[i] <= STOCK_RST[i];
		end else begin
			pc_q <= pc_d;
			if (ctl.op == OP_OUT && rsp_go)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			case (ctl.op)
				OP_COMMIT: begin
					if (rest_q == '0) begin
						balance_q <= balance_q - req_q.amount;
						for (int i = 0; i < NDEN; i++)
							stock_q[i] <= stock_q[i] - pick_q[i];
						if (full)
							hhead_q <= head_inc;
						else
							hcount_q <= hcount_q + 1'b1;
					end
				end
				OP_RSUM: begin
					for (int i = 0; i < NDEN; i++)
						stock_q[i] <= stk_rfl[i];
				end
				OP_RBAL:  balance_q <= bal_rfl;
				default: ;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req;
			status_q <= ST_OK;
		end
		case (ctl.op)
			OP_CHK: begin
				k_q    <= k_prod[K_SH +: UNIT_W];
				over_q <= req_q.amount > balance_q;
				for (int i = 0; i < NDEN; i++)
					pick_q[i] <= '0;
			end
			OP_MOD: begin
				rest_q <= k_q;
				if (over_q)
					status_q <= ST_OVER;
				else if (!mult_ok)
					status_q <= ST_NOT_MULT;
			end
			OP_DIV:  quo_q <= quo_d;
			OP_TAKE: begin
				pick_q[ctl.den] <= take_n;
				rest_q          <= rest_d;
			end
			OP_COMMIT: begin
				if (rest_q == '0) begin
					hist_q[full ? hhead_q : wr_idx] <= req_q.amount;
				end else begin
					status_q <= ST_SHORT;
					for (int i = 0; i < NDEN; i++)
						pick_q[i] <= '0;
				end
			end
			OP_RSUM: sum_q <= sum_d;
			OP_OUT: begin
				if (rsp_go)
					rsp_q <= rsp_d;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
